>>> hw/rtl/cmd_pkg.sv
`timescale 1ns / 1ps

package cmd_pkg;

    // field widths of the stream items
    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned POS_W      = 24;
    localparam int unsigned MASS_W     = 16;
    localparam int unsigned IDX_W      = 5;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned DENS_W     = 48;
    localparam int unsigned CSCALE_W   = 24;
    localparam int unsigned DSCALE_W   = 32;

    // internal arithmetic widths
    localparam int unsigned UNIT_W     = 32;   // scaled position, Q16.16
    localparam int unsigned INT_W      = 17;   // integer part after half-cell shift
    localparam int unsigned WGT_W      = 17;   // per-axis weight, up to 1.0 in Q1.16
    localparam int unsigned PROD_W     = 33;   // weight products, up to 2^32

    // configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    // stream widths
    localparam int unsigned S_TDATA_W  = 104;
    localparam int unsigned S_TUSER_W  = 2;
    localparam int unsigned M_TDATA_W  = 112;
    localparam int unsigned M_TUSER_W  = 1;

    localparam logic [DENS_W-1:0]   DENS_MAX     = '1;
    localparam logic [WGT_W-1:0]    WGT_ONE      = WGT_W'(65536);
    localparam logic [UNIT_W:0]     HALF_CELL    = (UNIT_W + 1)'(32768);
    localparam logic [CSCALE_W-1:0] CSCALE_RESET = CSCALE_W'(65536);
    localparam logic [DSCALE_W-1:0] DSCALE_RESET = DSCALE_W'(65536);

    typedef enum logic [1:0] {
        KIND_CLEAR   = 2'd0,
        KIND_DEPOSIT = 2'd1,
        KIND_READ    = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_SCALE    = 1'b0,
        CFG_DENSITY_SCALE = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_MOD_LOAD,
        ST_MOD_WAIT,
        ST_C_ADDR,
        ST_C_READ,
        ST_C_MUL,
        ST_C_WRITE,
        ST_RD_ISSUE,
        ST_RD_HI,
        ST_RD_LO,
        ST_RD_SUM,
        ST_DONE
    } t_state;

endpackage

>>> hw/rtl/cic_mass_deposit.sv
`timescale 1ns / 1ps

// Periodic 3D cloud-in-cell mass deposition engine on a GRID_SIDE^3 grid of 48-bit
// unsigned Q24.24 accumulators held in one grid memory with a registered read. Each
// stream request carries a kind in tuser: clear (zero the whole grid), deposit (scale the
// position by cell_scale, shift down half a cell, wrap periodically, then add mass times
// the eight trilinear weights into the eight neighbor cells with saturation) or read
// (return one cell times density_scale, saturated). Every request gives exactly one
// result; unused result fields are zero and the saturated flag covers only that request.
// Sequencing: one request is worked on at a time. A deposit passes, after it is accepted,
// through the position multipliers (ST_SCALE), the load of the wrap unit, the wrap unit
// itself (reciprocal multiply and one correcting subtract, all three axes in parallel),
// then for each corner ST_C_ADDR, ST_C_READ, ST_C_MUL and ST_C_WRITE for the weight
// multiplier chain and the read-modify-write on the grid memory, and ST_DONE to hand over
// the result. A read passes through the same wrap unit, the grid read and the two 48x16
// products; clear and unused kinds go straight to ST_DONE. The next request is taken in
// ST_IDLE once ST_DONE has handed over its result. After reset and after each clear the
// grid is swept one cell per cycle over all GRID_SIDE^3 cells (32768 at the default size),
// while no request is taken; configuration writes are taken at any time but are meant for
// an idle block. A finished result waits in an output register, so the input side is free
// again while the consumer stalls.

module cic_mass_deposit #(
    parameter int unsigned GRID_SIDE = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // pos_x, pos_y, pos_z, particle_mass, read_x, read_y, read_z, zero pad
    input  logic [cmd_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,
    // kind
    input  logic [cmd_pkg::S_TUSER_W-1:0]       i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // cell_x, cell_y, cell_z, frac_x, frac_y, frac_z, density, zero pad
    output logic [cmd_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    // saturated
    output logic [cmd_pkg::M_TUSER_W-1:0]       o_m_axis_tuser,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [cmd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cmd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned NA         = cmd_pkg::NUM_AXES;
    localparam int unsigned CELLS      = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int unsigned ADDR_W     = $clog2(CELLS);
    localparam int unsigned REM_W      = $clog2(GRID_SIDE);
    localparam int unsigned CELL_EXT_W = REM_W + cmd_pkg::IDX_W;

    localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SIDE_A     = ADDR_W'(GRID_SIDE);
    localparam logic [ADDR_W-1:0] SIDE_SQ    = ADDR_W'(GRID_SIDE * GRID_SIDE);
    localparam logic [REM_W-1:0]  SIDE_LAST  = REM_W'(GRID_SIDE - 1);
    localparam logic [cmd_pkg::UNIT_W:0] SPAN = (cmd_pkg::UNIT_W + 1)'(GRID_SIDE * 65536);

    // ---------------------------------------------------------------- registers
    cmd_pkg::t_state r_state, n_state;
    cmd_pkg::t_kind  r_kind;

    logic [cmd_pkg::CSCALE_W-1:0] r_cell_scale;
    logic [cmd_pkg::DSCALE_W-1:0] r_density_scale;

    logic [ADDR_W-1:0] r_clr_addr;
    logic [2:0]        r_corner;          // corner sequencer, bit a picks the upper cell on axis a

    // latched request payload
    logic [NA-1:0][cmd_pkg::POS_W-1:0] r_pos;
    logic [cmd_pkg::MASS_W-1:0]        r_mass;
    logic [NA-1:0][cmd_pkg::IDX_W-1:0] r_rd_idx;

    // per-axis position, cell pair and fraction
    logic [NA-1:0][cmd_pkg::UNIT_W-1:0] r_u;
    logic [NA-1:0][cmd_pkg::FRAC_W-1:0] r_frac;
    logic [NA-1:0][REM_W-1:0]           r_lo;
    logic [NA-1:0][REM_W-1:0]           r_up;

    // corner datapath
    logic [ADDR_W-1:0]              r_addr;
    logic [cmd_pkg::PROD_W-1:0]     r_p1;
    logic [cmd_pkg::PROD_W-1:0]     r_p2;
    logic [cmd_pkg::PROD_W-1:0]     r_add;

    // read scaling
    logic [63:0]                    r_hi;
    logic [cmd_pkg::DENS_W-1:0]     r_cellv;
    logic [cmd_pkg::DENS_W-1:0]     r_lo_p;

    // result being built
    logic [NA-1:0][cmd_pkg::IDX_W-1:0]  r_res_cell;
    logic [NA-1:0][cmd_pkg::FRAC_W-1:0] r_res_frac;
    logic [cmd_pkg::DENS_W-1:0]         r_res_dens;
    logic                               r_res_sat;

    // output register
    logic                          r_m_valid;
    logic [cmd_pkg::M_TDATA_W-1:0] r_m_data;
    logic [cmd_pkg::M_TUSER_W-1:0] r_m_user;

    // ---------------------------------------------------------------- wires
    logic s_accept;
    logic w_push;
    logic w_mod_start;
    logic w_mod_done;
    logic [NA-1:0][cmd_pkg::INT_W-1:0] w_mod_val;
    logic [NA-1:0][REM_W-1:0]          w_rem;
    logic [NA-1:0][cmd_pkg::FRAC_W-1:0] w_frac_ld;

    logic                          w_ram_we;
    logic [ADDR_W-1:0]             w_ram_waddr;
    logic [cmd_pkg::DENS_W-1:0]    w_ram_wdata;
    logic                          w_ram_re;
    logic [cmd_pkg::DENS_W-1:0]    w_ram_rdata;

    logic [NA-1:0][cmd_pkg::POS_W-1:0]  w_in_pos;
    logic [NA-1:0][cmd_pkg::IDX_W-1:0]  w_in_idx;
    logic [cmd_pkg::MASS_W-1:0]         w_in_mass;

    logic [NA-1:0][REM_W-1:0]           w_c;
    logic [NA-1:0][cmd_pkg::WGT_W-1:0]  w_wgt;
    logic [ADDR_W-1:0]                  w_addr;
    logic [NA-1:0][47:0]                w_prod_u;
    logic [NA-1:0][cmd_pkg::UNIT_W:0]   w_shift;
    logic [NA-1:0][CELL_EXT_W-1:0]      w_cell_ext;
    logic [33:0]                        w_prod1;
    logic [49:0]                        w_prod2;
    logic [48:0]                        w_prod3;
    logic [48:0]                        w_acc_sum;
    logic                               w_acc_sat;
    logic [cmd_pkg::DENS_W-1:0]         w_acc_data;
    logic [63:0]                        w_hi_prod;
    logic [63:0]                        w_lo_prod;
    logic [48:0]                        w_dsum;
    logic                               w_dsat;

    // ---------------------------------------------------------------- request unpack
    assign w_in_pos[0] = i_s_axis_tdata[23:0];
    assign w_in_pos[1] = i_s_axis_tdata[47:24];
    assign w_in_pos[2] = i_s_axis_tdata[71:48];
    assign w_in_mass   = i_s_axis_tdata[87:72];
    assign w_in_idx[0] = i_s_axis_tdata[92:88];
    assign w_in_idx[1] = i_s_axis_tdata[97:93];
    assign w_in_idx[2] = i_s_axis_tdata[102:98];

    assign s_accept = i_s_axis_tvalid & o_s_axis_tready;

    // ---------------------------------------------------------------- datapath logic
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            // position to cell units, truncated Q16.16
            w_prod_u[a] = r_pos[a] * r_cell_scale;
            // half-cell shift plus one span so the value stays positive
            w_shift[a]  = {1'b0, r_u[a]} + SPAN - cmd_pkg::HALF_CELL;
            if (r_kind == cmd_pkg::KIND_DEPOSIT) begin
                w_mod_val[a] = w_shift[a][cmd_pkg::UNIT_W:16];
                w_frac_ld[a] = w_shift[a][15:0];
            end else begin
                w_mod_val[a] = cmd_pkg::INT_W'(r_rd_idx[a]);
                w_frac_ld[a] = '0;
            end
            w_cell_ext[a] = CELL_EXT_W'(w_rem[a]);
            // corner selection: lower or upper cell and its weight
            w_c[a]   = r_corner[a] ? r_up[a] : r_lo[a];
            w_wgt[a] = r_corner[a] ? cmd_pkg::WGT_W'(r_frac[a])
                                   : cmd_pkg::WGT_ONE - cmd_pkg::WGT_W'(r_frac[a]);
        end
        w_addr = ADDR_W'(w_c[0]) * SIDE_SQ + ADDR_W'(w_c[1]) * SIDE_A + ADDR_W'(w_c[2]);

        // trilinear weight times mass, one multiply per cycle
        w_prod1 = w_wgt[0] * w_wgt[1];
        w_prod2 = r_p1 * w_wgt[2];
        w_prod3 = r_p2 * r_mass;

        // saturating accumulate into the cell just read
        w_acc_sum  = w_ram_rdata + r_add;
        w_acc_sat  = w_acc_sum[48];
        w_acc_data = w_acc_sat ? cmd_pkg::DENS_MAX : w_acc_sum[47:0];

        // density = cell * integer part + (cell * fraction) >> 16
        w_hi_prod = w_ram_rdata * r_density_scale[31:16];
        w_lo_prod = r_cellv * r_density_scale[15:0];
        w_dsum    = r_hi[47:0] + r_lo_p;
        w_dsat    = (r_hi[63:48] != '0) | w_dsum[48];
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cmd_pkg::ST_CLEAR: begin
                if (r_clr_addr == CELL_LAST) begin
                    n_state = cmd_pkg::ST_IDLE;
                end
            end
            cmd_pkg::ST_IDLE: begin
                if (s_accept) begin
                    unique case (cmd_pkg::t_kind'(i_s_axis_tuser))
                        cmd_pkg::KIND_DEPOSIT: n_state = cmd_pkg::ST_SCALE;
                        cmd_pkg::KIND_READ:    n_state = cmd_pkg::ST_MOD_LOAD;
                        cmd_pkg::KIND_CLEAR,
                        cmd_pkg::KIND_NONE:    n_state = cmd_pkg::ST_DONE;
                    endcase
                end
            end
            cmd_pkg::ST_SCALE:    n_state = cmd_pkg::ST_MOD_LOAD;
            cmd_pkg::ST_MOD_LOAD: n_state = cmd_pkg::ST_MOD_WAIT;
            cmd_pkg::ST_MOD_WAIT: begin
                if (w_mod_done) begin
                    n_state = cmd_pkg::ST_C_ADDR;
                end
            end
            cmd_pkg::ST_C_ADDR: begin
                n_state = (r_kind == cmd_pkg::KIND_READ) ? cmd_pkg::ST_RD_ISSUE
                                                         : cmd_pkg::ST_C_READ;
            end
            cmd_pkg::ST_C_READ:   n_state = cmd_pkg::ST_C_MUL;
            cmd_pkg::ST_C_MUL:    n_state = cmd_pkg::ST_C_WRITE;
            cmd_pkg::ST_C_WRITE: begin
                n_state = (r_corner == 3'd7) ? cmd_pkg::ST_DONE : cmd_pkg::ST_C_ADDR;
            end
            cmd_pkg::ST_RD_ISSUE: n_state = cmd_pkg::ST_RD_HI;
            cmd_pkg::ST_RD_HI:    n_state = cmd_pkg::ST_RD_LO;
            cmd_pkg::ST_RD_LO:    n_state = cmd_pkg::ST_RD_SUM;
            cmd_pkg::ST_RD_SUM:   n_state = cmd_pkg::ST_DONE;
            cmd_pkg::ST_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_state = (r_kind == cmd_pkg::KIND_CLEAR) ? cmd_pkg::ST_CLEAR
                                                              : cmd_pkg::ST_IDLE;
                end
            end
            default: n_state = cmd_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_mod_start     = 1'b0;
        w_push          = 1'b0;
        w_ram_we        = 1'b0;
        w_ram_waddr     = r_addr;
        w_ram_wdata     = w_acc_data;
        w_ram_re        = 1'b0;
        unique case (r_state)
            cmd_pkg::ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
            end
            cmd_pkg::ST_IDLE:     o_s_axis_tready = 1'b1;
            cmd_pkg::ST_MOD_LOAD: w_mod_start     = 1'b1;
            cmd_pkg::ST_C_READ,
            cmd_pkg::ST_RD_ISSUE: w_ram_re        = 1'b1;
            cmd_pkg::ST_C_WRITE:  w_ram_we        = 1'b1;
            cmd_pkg::ST_DONE:     w_push          = !r_m_valid || i_m_axis_tready;
            cmd_pkg::ST_SCALE,
            cmd_pkg::ST_MOD_WAIT,
            cmd_pkg::ST_C_ADDR,
            cmd_pkg::ST_C_MUL,
            cmd_pkg::ST_RD_HI,
            cmd_pkg::ST_RD_LO,
            cmd_pkg::ST_RD_SUM: begin
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cmd_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_corner   <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_accept) begin
                r_clr_addr <= '0;
                r_corner   <= '0;
            end else begin
                if (r_state == cmd_pkg::ST_CLEAR) begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                end
                if (r_state == cmd_pkg::ST_C_WRITE) begin
                    r_corner <= r_corner + 3'd1;
                end
            end
            if (w_push) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_scale    <= cmd_pkg::CSCALE_RESET;
            r_density_scale <= cmd_pkg::DSCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (cmd_pkg::t_cfg_reg'(i_cfg_index))
                cmd_pkg::CFG_CELL_SCALE:
                    r_cell_scale <= i_cfg_data[cmd_pkg::CSCALE_W-1:0];
                cmd_pkg::CFG_DENSITY_SCALE:
                    r_density_scale <= i_cfg_data[cmd_pkg::DSCALE_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kind     <= cmd_pkg::t_kind'(i_s_axis_tuser);
            r_pos      <= w_in_pos;
            r_mass     <= w_in_mass;
            r_rd_idx   <= w_in_idx;
            r_res_cell <= '0;
            r_res_frac <= '0;
            r_res_dens <= '0;
            r_res_sat  <= 1'b0;
        end
        unique case (r_state)
            cmd_pkg::ST_SCALE: begin
                for (int a = 0; a < NA; a++) begin
                    r_u[a] <= w_prod_u[a][47:16];
                end
            end
            cmd_pkg::ST_MOD_LOAD: r_frac <= w_frac_ld;
            cmd_pkg::ST_MOD_WAIT: begin
                if (w_mod_done) begin
                    for (int a = 0; a < NA; a++) begin
                        r_lo[a] <= w_rem[a];
                        r_up[a] <= (w_rem[a] == SIDE_LAST) ? '0 : w_rem[a] + REM_W'(1);
                        if (r_kind == cmd_pkg::KIND_DEPOSIT) begin
                            r_res_cell[a] <= w_cell_ext[a][cmd_pkg::IDX_W-1:0];
                            r_res_frac[a] <= r_frac[a];
                        end
                    end
                end
            end
            cmd_pkg::ST_C_ADDR: begin
                r_addr <= w_addr;
                r_p1   <= w_prod1[cmd_pkg::PROD_W-1:0];
            end
            cmd_pkg::ST_C_READ:  r_p2 <= w_prod2[48:16];
            cmd_pkg::ST_C_MUL:   r_add <= w_prod3[48:16];
            cmd_pkg::ST_C_WRITE: r_res_sat <= r_res_sat | w_acc_sat;
            cmd_pkg::ST_RD_HI: begin
                r_hi    <= w_hi_prod;
                r_cellv <= w_ram_rdata;
            end
            cmd_pkg::ST_RD_LO:  r_lo_p <= w_lo_prod[63:16];
            cmd_pkg::ST_RD_SUM: begin
                r_res_dens <= w_dsat ? cmd_pkg::DENS_MAX : w_dsum[47:0];
                r_res_sat  <= w_dsat;
            end
            cmd_pkg::ST_CLEAR,
            cmd_pkg::ST_IDLE,
            cmd_pkg::ST_RD_ISSUE,
            cmd_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
        if (w_push) begin
            r_m_data <= {1'b0, r_res_dens,
                         r_res_frac[2], r_res_frac[1], r_res_frac[0],
                         r_res_cell[2], r_res_cell[1], r_res_cell[0]};
            r_m_user <= r_res_sat;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    // ---------------------------------------------------------------- units
    cmd_mod #(
        .GRID_SIDE (GRID_SIDE),
        .REM_W     (REM_W)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_val   (w_mod_val),
        .o_done  (w_mod_done),
        .o_rem   (w_rem)
    );

    cmd_ram #(
        .WIDTH (cmd_pkg::DENS_W),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_addr),
        .o_rdata (w_ram_rdata)
    );

endmodule

>>> hw/rtl/cmd_ram.sv
`timescale 1ns / 1ps

module cmd_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 32768,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/cmd_mod.sv
`timescale 1ns / 1ps

module cmd_mod #(
    parameter int unsigned GRID_SIDE = 32,
    parameter int unsigned REM_W     = $clog2(GRID_SIDE)
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic [cmd_pkg::NUM_AXES-1:0][cmd_pkg::INT_W-1:0] i_val,
    output logic                                          o_done,
    output logic [cmd_pkg::NUM_AXES-1:0][REM_W-1:0]       o_rem
);

    localparam int unsigned QUO_W = cmd_pkg::INT_W - 1;
    localparam int unsigned MUL_W = 2 * cmd_pkg::INT_W;
    // floor(2^INT_W / side): the quotient estimate is exact or one too small
    localparam logic [cmd_pkg::INT_W-1:0] RECIP =
        cmd_pkg::INT_W'((1 << cmd_pkg::INT_W) / GRID_SIDE);
    localparam logic [cmd_pkg::INT_W-1:0] SIDE_V = cmd_pkg::INT_W'(GRID_SIDE);
    localparam logic [REM_W:0]            SIDE_T = (REM_W + 1)'(GRID_SIDE);
    localparam logic [1:0]                STEPS  = 2'd2;

    logic [1:0] r_cnt;
    logic [cmd_pkg::NUM_AXES-1:0][cmd_pkg::INT_W-1:0] r_val;
    logic [cmd_pkg::NUM_AXES-1:0][QUO_W-1:0]          r_quo;
    logic [cmd_pkg::NUM_AXES-1:0][REM_W-1:0]          r_rem;
    logic [cmd_pkg::NUM_AXES-1:0][MUL_W-1:0]          w_prod;
    logic [cmd_pkg::NUM_AXES-1:0][cmd_pkg::INT_W-1:0] w_diff;
    logic [cmd_pkg::NUM_AXES-1:0][REM_W:0]            w_part;
    logic [cmd_pkg::NUM_AXES-1:0][REM_W-1:0]          n_rem;

    // quotient by reciprocal multiply, then one compare and subtract fixes the remainder
    always_comb begin
        for (int a = 0; a < cmd_pkg::NUM_AXES; a++) begin
            w_prod[a] = MUL_W'(r_val[a]) * MUL_W'(RECIP);
            w_diff[a] = r_val[a] - cmd_pkg::INT_W'(r_quo[a]) * SIDE_V;
            w_part[a] = w_diff[a][REM_W:0];
            if (w_part[a] >= SIDE_T) begin
                n_rem[a] = REM_W'(w_part[a] - SIDE_T);
            end else begin
                n_rem[a] = REM_W'(w_part[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= STEPS;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_val;
        end
        if (r_cnt == STEPS) begin
            for (int a = 0; a < cmd_pkg::NUM_AXES; a++) begin
                r_quo[a] <= w_prod[a][cmd_pkg::INT_W +: QUO_W];
            end
        end
        if (r_cnt == 2'd1) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_rem  = r_rem;

endmodule
